/* design/fss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame segmented stack package
// Request and result types, command and status codes, and register indexes
// shared by the frame segmented stack unit.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int SIZE_W      = 11;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [SIZE_W-1:0] INIT_SIZE_RESET     = 11'd64;
  localparam logic              OPEN_AT_RESET_RESET = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_FRAME_SIZE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_FRAME_AT_RESET = 1'd1;

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_PUSH  = 2'd2,
    CMD_POP   = 2'd3
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_FRAME = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NO_SPACE = 3'd4
  } status_t;

  typedef struct packed {
    command_t             command;
    logic [SIZE_W-1:0]    frame_size;
    logic [VALUE_W-1:0]   push_value;
  } request_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   pop_value;
    status_t              status;
    logic [COUNT_W-1:0]   frame_count;
    logic [SIZE_W-1:0]    frame_occupied;
  } result_t;

endpackage
`default_nettype wire

/* design/frame_segmented_stack_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame segmented stack unit
// A stack of frames, each a small last-in-first-out stack of fixed capacity,
// carved one after another out of a single entry memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result is
// registered and shown for a single cycle with done high, and must be
// captured then, as the unit cannot be held off. Open, push, close of the
// only open frame and every refused request give their result in the cycle
// after they are taken. A successful pop first reads the entry memory into
// its output register, and closing a frame that lies over another first
// reads the older frame's descriptor from the descriptor memory into its
// output register; each then gives its result from the read state, in which
// busy is high. The newest frame's descriptor is held in registers, the
// older ones in the descriptor memory. A configuration write discards all
// frames and sets up the reset state again from the current register values;
// the entry memory keeps its contents and needs no clearing after reset.
// ----------------------------------------------------------------------------
module frame_segmented_stack_unit #(
  parameter int ENTRY_DEPTH = 1024,
  parameter int MAX_FRAMES  = 64,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  fss_pkg::request_t                  request,
  output logic                               done,
  output fss_pkg::result_t                   result,
  input  logic                               cfg_we,
  input  logic [fss_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fss_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fss_pkg::*;

  localparam int AW  = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int CW  = $clog2(ENTRY_DEPTH + 1);
  localparam int FIW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FW  = $clog2(MAX_FRAMES + 1);
  localparam int SW  = ((CW > SIZE_W) ? CW : SIZE_W) + 1;

  typedef struct packed {
    logic [CW-1:0] base;
    logic [CW-1:0] capacity;
    logic [CW-1:0] free;
  } desc_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                 state;
  logic                   pend_close;
  logic [FW-1:0]          open_frames;
  logic [CW-1:0]          next_free;
  desc_t                  top;
  logic [SIZE_W-1:0]      init_size;
  logic                   open_at_reset;

  desc_t                  desc_mem [MAX_FRAMES];
  desc_t                  desc_rdata;
  logic [ENTRY_WIDTH-1:0] entry_mem [ENTRY_DEPTH];
  logic [ENTRY_WIDTH-1:0] entry_rdata;

  logic                   accept;
  logic                   have_frame;
  logic [CW-1:0]          occ_top;
  logic [CW-1:0]          occ_desc;
  logic [SW-1:0]          room;
  logic                   open_ok;
  logic                   push_ok;
  logic                   pop_ok;
  logic [CW-1:0]          push_addr;
  logic [CW-1:0]          pop_addr;
  logic                   entry_we;
  logic                   entry_re;
  logic                   desc_we;
  logic                   desc_re;
  logic [FW-1:0]          desc_waddr;
  logic [FW-1:0]          desc_raddr;

  logic [SIZE_W-1:0]      rs_size;
  logic                   rs_open;
  logic                   rs_fits;
  logic [CW-1:0]          rs_cap;

  assign busy       = (state == S_READ);
  assign accept     = start && (state == S_IDLE);
  assign have_frame = (open_frames != '0);
  assign occ_top    = top.capacity - top.free;
  assign occ_desc   = desc_rdata.capacity - desc_rdata.free;
  assign room       = SW'(ENTRY_DEPTH) - SW'(next_free);
  assign open_ok    = (open_frames < FW'(MAX_FRAMES)) && (SW'(request.frame_size) <= room);
  assign push_ok    = have_frame && (top.free != '0);
  assign pop_ok     = have_frame && (top.free < top.capacity);
  assign push_addr  = top.base + top.free - CW'(1);
  assign pop_addr   = top.base + top.free;

  assign entry_we   = accept && (request.command == CMD_PUSH) && push_ok
                      && (push_addr < CW'(ENTRY_DEPTH));
  assign entry_re   = accept && (request.command == CMD_POP) && pop_ok;
  assign desc_we    = accept && (request.command == CMD_OPEN) && open_ok && have_frame;
  assign desc_re    = accept && (request.command == CMD_CLOSE) && (open_frames > FW'(1));
  assign desc_waddr = open_frames - FW'(1);
  assign desc_raddr = open_frames - FW'(2);

  always_comb begin
    rs_size = init_size;
    rs_open = open_at_reset;
    if (rst) begin
      rs_size = INIT_SIZE_RESET;
      rs_open = OPEN_AT_RESET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INITIAL_FRAME_SIZE:  rs_size = cfg_data;
        CFG_OPEN_FRAME_AT_RESET: rs_open = cfg_data[0];
        default: ;
      endcase
    end
    rs_fits = rs_open && (SW'(rs_size) <= SW'(ENTRY_DEPTH));
    rs_cap  = rs_fits ? CW'(rs_size) : '0;
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[push_addr[AW-1:0]] <= ENTRY_WIDTH'(request.push_value);
    end
    if (entry_re) begin
      entry_rdata <= entry_mem[pop_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_waddr[FIW-1:0]] <= top;
    end
    if (desc_re) begin
      desc_rdata <= desc_mem[desc_raddr[FIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      pend_close    <= 1'b0;
      open_frames   <= rs_fits ? FW'(1) : '0;
      next_free     <= rs_cap;
      top.base      <= '0;
      top.capacity  <= rs_cap;
      top.free      <= rs_cap;
      init_size     <= rs_size;
      open_at_reset <= rs_open;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            done                  <= 1'b1;
            result.pop_value      <= '0;
            result.status         <= ST_OK;
            result.frame_count    <= COUNT_W'(open_frames);
            result.frame_occupied <= have_frame ? SIZE_W'(occ_top) : '0;
            case (request.command)
              CMD_OPEN: begin
                if (open_ok) begin
                  top.base              <= next_free;
                  top.capacity          <= CW'(request.frame_size);
                  top.free              <= CW'(request.frame_size);
                  next_free             <= next_free + CW'(request.frame_size);
                  open_frames           <= open_frames + FW'(1);
                  result.frame_count    <= COUNT_W'(open_frames + FW'(1));
                  result.frame_occupied <= '0;
                end else begin
                  result.status <= ST_NO_SPACE;
                end
              end
              CMD_CLOSE: begin
                if (!have_frame) begin
                  result.status <= ST_NO_FRAME;
                end else begin
                  next_free             <= top.base;
                  open_frames           <= open_frames - FW'(1);
                  result.frame_count    <= COUNT_W'(open_frames - FW'(1));
                  result.frame_occupied <= '0;
                  if (open_frames > FW'(1)) begin
                    done       <= 1'b0;
                    pend_close <= 1'b1;
                    state      <= S_READ;
                  end
                end
              end
              CMD_PUSH: begin
                if (!have_frame) begin
                  result.status <= ST_NO_FRAME;
                end else if (!push_ok) begin
                  result.status <= ST_FULL;
                end else begin
                  top.free              <= top.free - CW'(1);
                  result.frame_occupied <= SIZE_W'(occ_top + CW'(1));
                end
              end
              CMD_POP: begin
                if (!have_frame) begin
                  result.status <= ST_NO_FRAME;
                end else if (!pop_ok) begin
                  result.status <= ST_EMPTY;
                end else begin
                  top.free   <= top.free + CW'(1);
                  done       <= 1'b0;
                  pend_close <= 1'b0;
                  state      <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          done               <= 1'b1;
          state              <= S_IDLE;
          result.status      <= ST_OK;
          result.frame_count <= COUNT_W'(open_frames);
          if (pend_close) begin
            top                   <= desc_rdata;
            result.pop_value      <= '0;
            result.frame_occupied <= SIZE_W'(occ_desc);
          end else begin
            result.pop_value      <= VALUE_W'(entry_rdata);
            result.frame_occupied <= SIZE_W'(occ_top);
          end
        end
        default: begin
          state <= S_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
